// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// expression holds on every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

// File: rtl/mde_pkg.sv
// types, constants and helpers of the marker delimited text extractor
package mde_pkg;

  localparam int unsigned MarkerMaxDef = 8;
  localparam int unsigned LenW         = 4;
  localparam int unsigned MarkerW      = 64;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned LineW        = 32;
  localparam int unsigned CfgAddrW     = 5;
  localparam int unsigned CfgDataW     = 64;

  localparam logic [ByteW-1:0] NewlineChar = 8'h0A;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_START   = 2'd1,
    MODE_MESSAGE = 2'd2,
    MODE_STOP    = 2'd3
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_MSG   = 2'd1,
    KIND_END   = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_START_LENGTH = 2'd1,
    REG_STOP_MARKER  = 2'd2,
    REG_STOP_LENGTH  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_STEP   = 2'd1,
    ST_REPLAY = 2'd2
  } ctrl_state_e;

  typedef logic [2:0] lane_idx_t;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       out_kind;
    logic [ByteW-1:0] out_byte;
    logic [LineW-1:0] message_line;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [MarkerW-1:0] start_marker;
    logic [LenW-1:0]    start_length;
    logic [MarkerW-1:0] stop_marker;
    logic [LenW-1:0]    stop_length;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      load;
    logic      open_match;
    logic      advance;
    logic      begin_msg;
    logic      close_msg;
    logic      rep_clear;
    logic      rep_step;
    logic      rep_done;
    logic      emit;
    out_kind_e emit_kind;
    logic      emit_lane;
    logic      emit_last;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    scan_mode_e mode;
    logic       hit_start0;
    logic       hit_stop0;
    logic       done;
    logic       mism;
    logic       rep_last;
    logic       out_free;
  } dp_status_t;

  function automatic logic [ByteW-1:0] lane_byte(input logic [MarkerW-1:0] marker,
                                                 input lane_idx_t idx);
    return marker[{idx, 3'b000} +: ByteW];
  endfunction

endpackage

// File: rtl/mde_stream_if.sv
// valid/ready stream interfaces for the input bytes and the results
interface mde_in_if;
  import mde_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mde_out_if;
  import mde_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/mde_regs.sv
// apb configuration registers: start and stop markers and their lengths
module mde_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mde_pkg::CfgAddrW-1:0] paddr,
  input  logic [mde_pkg::CfgDataW-1:0] pwdata,
  output logic [mde_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  output mde_pkg::cfg_t                cfg_o
);
  import mde_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[CfgAddrW-1:3]);
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= '0;
      cfg_q.start_length <= LenW'(1);
      cfg_q.stop_marker  <= '0;
      cfg_q.stop_length  <= LenW'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_MARKER: cfg_q.start_marker <= pwdata[MarkerW-1:0];
        REG_START_LENGTH: cfg_q.start_length <= pwdata[LenW-1:0];
        REG_STOP_MARKER:  cfg_q.stop_marker  <= pwdata[MarkerW-1:0];
        REG_STOP_LENGTH:  cfg_q.stop_length  <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_MARKER: prdata = CfgDataW'(cfg_q.start_marker);
      REG_START_LENGTH: prdata = CfgDataW'(cfg_q.start_length);
      REG_STOP_MARKER:  prdata = CfgDataW'(cfg_q.stop_marker);
      REG_STOP_LENGTH:  prdata = CfgDataW'(cfg_q.stop_length);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/mde_ctrl.sv
// controller state machine that sequences the steps and results of one byte
module mde_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mde_pkg::dp_status_t status_i,
  output mde_pkg::ctrl_cmd_t  cmd_o
);
  import mde_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        hit_own;
  logic        text_side;

  // text side modes compare against the start marker, message side against the stop marker
  assign text_side = (status_i.mode == MODE_NORMAL) || (status_i.mode == MODE_START);
  assign hit_own   = text_side ? status_i.hit_start0 : status_i.hit_stop0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_STEP;
      end
      ST_STEP: begin
        unique case (status_i.mode) inside
          MODE_NORMAL, MODE_MESSAGE: begin
            if (hit_own || status_i.out_free) state_d = ST_IDLE;
          end
          MODE_START, MODE_STOP: begin
            if (status_i.done) begin
              state_d = ST_STEP;
            end else if (status_i.mism) begin
              state_d = ST_REPLAY;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_REPLAY: begin
        if (status_i.out_free && status_i.rep_last) state_d = ST_STEP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = KIND_PLAIN;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_STEP: begin
        unique case (status_i.mode) inside
          MODE_NORMAL, MODE_MESSAGE: begin
            if (hit_own) begin
              cmd_o.open_match = 1'b1;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = text_side ? KIND_PLAIN : KIND_MSG;
              cmd_o.emit_last = 1'b1;
            end
          end
          MODE_START: begin
            if (status_i.done) begin
              cmd_o.begin_msg = 1'b1;
            end else if (status_i.mism) begin
              cmd_o.rep_clear = 1'b1;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          MODE_STOP: begin
            if (status_i.done) begin
              // end result, then the byte is taken again in plain text mode
              if (status_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_END;
                cmd_o.emit_last = status_i.hit_start0;
                cmd_o.close_msg = 1'b1;
              end
            end else if (status_i.mism) begin
              cmd_o.rep_clear = 1'b1;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_REPLAY: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = text_side ? KIND_PLAIN : KIND_MSG;
          cmd_o.emit_lane = 1'b1;
          // last only if the reprocessed byte will open a new match
          cmd_o.emit_last = status_i.rep_last && hit_own;
          cmd_o.rep_step  = 1'b1;
          cmd_o.rep_done  = status_i.rep_last;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/mde_datapath.sv
// scan state, line counter, marker compare and the output register
module mde_datapath #(
  parameter int unsigned MarkerMax = mde_pkg::MarkerMaxDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mde_pkg::cfg_t             cfg_i,
  input  mde_pkg::ctrl_cmd_t        cmd_i,
  input  logic [mde_pkg::ByteW-1:0] in_byte_i,
  input  logic                      out_ready_i,
  output mde_pkg::dp_status_t       status_o,
  output logic                      out_valid_o,
  output mde_pkg::out_item_t        out_item_o
);
  import mde_pkg::*;

  localparam int unsigned PosW = $clog2(MarkerMax + 1);
  localparam int unsigned IdxW = (MarkerMax > 1) ? $clog2(MarkerMax) : 1;
  localparam logic [LenW-1:0] LenMax = LenW'(MarkerMax);

  scan_mode_e         mode_q, mode_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [LineW-1:0]   line_q, line_d;
  logic [LineW-1:0]   sline_q, sline_d;
  logic [ByteW-1:0]   ch_q;
  logic               out_valid_q;
  out_item_t          out_q, item_d;

  logic               text_side;
  logic [MarkerW-1:0] marker_sel;
  logic [LenW-1:0]    len_raw, len_eff;
  logic               out_free;

  assign text_side  = (mode_q == MODE_NORMAL) || (mode_q == MODE_START);
  assign marker_sel = text_side ? cfg_i.start_marker : cfg_i.stop_marker;
  assign len_raw    = text_side ? cfg_i.start_length : cfg_i.stop_length;
  assign out_free   = !out_valid_q || out_ready_i;

  // lengths outside one to the maximum are clamped
  always_comb begin
    if (len_raw == '0) begin
      len_eff = LenW'(1);
    end else if (len_raw > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = len_raw;
    end
  end

  assign status_o.mode       = mode_q;
  assign status_o.hit_start0 = ch_q == lane_byte(cfg_i.start_marker, lane_idx_t'(0));
  assign status_o.hit_stop0  = ch_q == lane_byte(cfg_i.stop_marker, lane_idx_t'(0));
  assign status_o.done       = LenW'(pos_q) >= len_eff;
  assign status_o.mism       = ch_q != lane_byte(marker_sel, lane_idx_t'(pos_q));
  assign status_o.rep_last   = (PosW'(idx_q) + PosW'(1)) == pos_q;
  assign status_o.out_free   = out_free;

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    line_d  = line_q;
    sline_d = sline_q;
    // saturating newline count, taken before the byte is processed
    if (cmd_i.load && (in_byte_i == NewlineChar) && (line_q != '1)) begin
      line_d = line_q + LineW'(1);
    end
    if (cmd_i.open_match) begin
      mode_d = text_side ? MODE_START : MODE_STOP;
      pos_d  = PosW'(1);
    end
    if (cmd_i.advance) begin
      pos_d = pos_q + PosW'(1);
    end
    if (cmd_i.begin_msg) begin
      mode_d  = MODE_MESSAGE;
      pos_d   = '0;
      sline_d = line_q;
    end
    if (cmd_i.close_msg) begin
      mode_d = MODE_NORMAL;
      pos_d  = '0;
    end
    if (cmd_i.rep_done) begin
      mode_d = text_side ? MODE_NORMAL : MODE_MESSAGE;
      pos_d  = '0;
    end
    if (cmd_i.rep_clear) begin
      idx_d = '0;
    end
    if (cmd_i.rep_step) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    item_d.out_kind = cmd_i.emit_kind;
    if (cmd_i.emit_kind == KIND_END) begin
      item_d.out_byte = '0;
    end else if (cmd_i.emit_lane) begin
      item_d.out_byte = lane_byte(marker_sel, lane_idx_t'(idx_q));
    end else begin
      item_d.out_byte = ch_q;
    end
    item_d.message_line = (cmd_i.emit_kind == KIND_PLAIN) ? '0 : sline_q;
    item_d.last_of_run  = cmd_i.emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      pos_q       <= '0;
      idx_q       <= '0;
      line_q      <= '0;
      sline_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      line_q  <= line_d;
      sline_q <= sline_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q <= in_byte_i;
    end
    if (cmd_i.emit) begin
      out_q <= item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/marker_delimited_text_extractor.sv
// Marker delimited text extractor: splits a byte stream into plain text bytes and
// message bytes found between a start marker and a stop marker (up to MarkerMax bytes
// each, set over the apb port), matched byte by byte without a fallback table. A broken
// start match replays its prefix as plain bytes, a broken stop match replays its prefix
// as message bytes, and a finished message gives an end result with the saturating
// newline count taken when it began. Results leave through a registered output stage,
// one per cycle at most, and the last result of each byte is flagged. The controller
// takes one byte at a time, finishing it before it accepts the next, and waits while
// the output register is full.
`include "assert_macros.svh"

module marker_delimited_text_extractor #(
  parameter int unsigned MarkerMax = mde_pkg::MarkerMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mde_in_if.sink                       in_i,
  mde_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mde_pkg::CfgAddrW-1:0] paddr,
  input  logic [mde_pkg::CfgDataW-1:0] pwdata,
  output logic [mde_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);
  import mde_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  mde_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mde_datapath #(
    .MarkerMax (MarkerMax)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .in_byte_i   (in_i.payload.in_byte),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload)
  );

  `ASSERT_IMPL(a_emit_has_room, cmd.emit, status.out_free,
               "result issued while the output register is full")
  `ASSERT_IMPL(a_replay_in_match, cmd.rep_step,
               (status.mode == MODE_START) || (status.mode == MODE_STOP),
               "marker prefix replayed outside a match")
  `ASSERT_ALWAYS(a_mode_cmds_excl,
                 $onehot0({cmd.open_match, cmd.advance, cmd.begin_msg, cmd.close_msg,
                           cmd.rep_done}),
                 "conflicting scan mode updates")
  `ASSERT_NEXT(a_open_enters_match, cmd.open_match,
               (status.mode == MODE_START) || (status.mode == MODE_STOP),
               "marker match not entered after first byte hit")

endmodule
